// ===== rtl/llcg_pkg.sv =====
// ----------------------------------------------------------------------------
// llcg_pkg
// Shared widths, constants and the word type passed from front to back.
// ----------------------------------------------------------------------------
package llcg_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = 33;
  localparam int MAG_W   = 32;
  localparam int SQ_W    = 64;
  localparam int SUM_W   = 66;
  localparam int DIST_W  = 33;
  localparam int LEN_W   = 32;
  localparam int PEN_W   = 33;
  localparam int REST_W  = 17;
  localparam int NORM_W  = 18;
  localparam int QUO_W   = 17;
  localparam int FRAC_W  = 16;
  localparam int NUM_W   = 49;
  localparam int AXES    = 3;

  localparam logic [REST_W-1:0] REST_ONE = REST_W'(65536);

  localparam logic LINK_CABLE = 1'b0;
  localparam logic LINK_ROD   = 1'b1;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic                             contact;
    logic                             flip;
    logic [AXES-1:0][DIFF_W-1:0]      d;
    logic [DIST_W-1:0]                span;
    logic [PEN_W-1:0]                 pen;
    logic [REST_W-1:0]                rest;
  } link_word_t;

endpackage

// ===== rtl/llcg_front.sv =====
// ----------------------------------------------------------------------------
// llcg_front
// Differences, squares, bit-per-stage square root and contact classification.
// ----------------------------------------------------------------------------
module llcg_front import llcg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic                 in_link_kind,
  input  logic [COORD_W-1:0]   in_point_a_x,
  input  logic [COORD_W-1:0]   in_point_a_y,
  input  logic [COORD_W-1:0]   in_point_a_z,
  input  logic [COORD_W-1:0]   in_point_b_x,
  input  logic [COORD_W-1:0]   in_point_b_y,
  input  logic [COORD_W-1:0]   in_point_b_z,
  input  logic [LEN_W-1:0]     in_target_length,
  input  logic [REST_W-1:0]    in_restitution_in,
  output link_word_t           q_word,
  output logic                 q_push,
  input  logic                 q_full
);

  localparam int STEPS = DIST_W;

  typedef struct packed {
    logic                        kind;
    logic [LEN_W-1:0]            len;
    logic [REST_W-1:0]           rest;
    logic [AXES-1:0][DIFF_W-1:0] d;
  } side_t;

  logic front_en;
  logic out_v_r;
  link_word_t out_w_r;

  assign front_en = !out_v_r || !q_full;
  assign in_full  = !front_en;
  assign q_push   = out_v_r && !q_full;
  assign q_word   = out_w_r;

  // stage a: differences
  logic  va_r;
  side_t sa_r;
  side_t sa_nxt;

  always_comb begin
    sa_nxt.kind = in_link_kind;
    sa_nxt.len  = in_target_length;
    sa_nxt.rest = in_restitution_in;
    sa_nxt.d[0] = {in_point_b_x[COORD_W-1], in_point_b_x} - {in_point_a_x[COORD_W-1], in_point_a_x};
    sa_nxt.d[1] = {in_point_b_y[COORD_W-1], in_point_b_y} - {in_point_a_y[COORD_W-1], in_point_a_y};
    sa_nxt.d[2] = {in_point_b_z[COORD_W-1], in_point_b_z} - {in_point_a_z[COORD_W-1], in_point_a_z};
  end

  // stage b: squares
  logic                      vb_r;
  side_t                     sb_r;
  logic [AXES-1:0][SQ_W-1:0] sq_r;
  logic [AXES-1:0][SQ_W-1:0] sq_nxt;
  logic [AXES-1:0][DIFF_W-1:0] mag_full;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      mag_full[i] = sa_r.d[i][DIFF_W-1] ? (DIFF_W'(0) - sa_r.d[i]) : sa_r.d[i];
      sq_nxt[i]   = SQ_W'(mag_full[i][MAG_W-1:0]) * SQ_W'(mag_full[i][MAG_W-1:0]);
    end
  end

  // root pipeline, index 0 holds the sum
  logic        v_r    [0:STEPS];
  side_t       side_r [0:STEPS];
  logic [SUM_W-1:0]  rem_r  [0:STEPS];
  logic [DIST_W-1:0] root_r [0:STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r   <= 1'b0;
      vb_r   <= 1'b0;
      v_r[0] <= 1'b0;
    end else if (front_en) begin
      va_r   <= in_push;
      vb_r   <= va_r;
      v_r[0] <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (front_en) begin
      sa_r      <= sa_nxt;
      sb_r      <= sa_r;
      sq_r      <= sq_nxt;
      side_r[0] <= sb_r;
      rem_r[0]  <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
      root_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_root
    localparam int B = STEPS - 1 - k;
    logic [SUM_W-1:0] trial;
    logic             take;
    assign trial = (SUM_W'(root_r[k]) << (B + 1)) | (SUM_W'(1) << (2 * B));
    assign take  = rem_r[k] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (front_en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (front_en) begin
        side_r[k+1] <= side_r[k];
        rem_r[k+1]  <= take ? rem_r[k] - trial : rem_r[k];
        root_r[k+1] <= take ? (root_r[k] | (DIST_W'(1) << B)) : root_r[k];
      end
    end
  end

  // classification
  logic [DIST_W-1:0] span;
  logic [DIST_W-1:0] len_x;
  logic              over;
  link_word_t        cls_nxt;

  always_comb begin
    span  = root_r[STEPS];
    len_x = DIST_W'(side_r[STEPS].len);
    over  = span > len_x;
    cls_nxt.d    = side_r[STEPS].d;
    cls_nxt.span = span;
    cls_nxt.pen  = over ? PEN_W'(span - len_x) : PEN_W'(len_x - span);
    if (side_r[STEPS].kind == LINK_ROD) begin
      cls_nxt.contact = span != len_x;
      cls_nxt.flip    = !over;
      cls_nxt.rest    = '0;
    end else begin
      cls_nxt.contact = span >= len_x;
      cls_nxt.flip    = 1'b0;
      cls_nxt.rest    = (side_r[STEPS].rest > REST_ONE) ? REST_ONE : side_r[STEPS].rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (front_en) begin
      out_v_r <= v_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (front_en) begin
      out_w_r <= cls_nxt;
    end
  end

endmodule

// ===== rtl/llcg_queue.sv =====
// ----------------------------------------------------------------------------
// llcg_queue
// Small queue of classified words between the front and back parts.
// ----------------------------------------------------------------------------
module llcg_queue import llcg_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  link_word_t push_word,
  output logic       full,
  input  logic       pop,
  output link_word_t head_word,
  output logic       empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  link_word_t       mem [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full      = cnt_r == FULL_CNT;
  assign empty     = cnt_r == '0;
  assign head_word = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_word;
    end
  end

endmodule

// ===== rtl/llcg_back.sv =====
// ----------------------------------------------------------------------------
// llcg_back
// Pipelined restoring dividers for the normal and the result register.
// ----------------------------------------------------------------------------
module llcg_back import llcg_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  link_word_t          q_word,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output logic                out_contact_valid,
  output logic [NORM_W-1:0]   out_normal_x,
  output logic [NORM_W-1:0]   out_normal_y,
  output logic [NORM_W-1:0]   out_normal_z,
  output logic [PEN_W-1:0]    out_penetration_depth,
  output logic [REST_W-1:0]   out_restitution_out
);

  localparam int STEPS = QUO_W;

  logic back_en;
  logic out_v_r;

  assign back_en   = !out_v_r || out_pop;
  assign q_pop     = back_en && !q_empty;
  assign out_empty = !out_v_r;

  logic                        v_r   [0:STEPS];
  link_word_t                  w_r   [0:STEPS];
  logic [AXES-1:0][NUM_W-1:0]  rem_r [0:STEPS];
  logic [AXES-1:0][QUO_W-1:0]  quo_r [0:STEPS];
  logic [AXES-1:0][NUM_W-1:0]  num_nxt;
  logic [AXES-1:0][DIFF_W-1:0] mag;

  // numerator with half the divisor added for round half up
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      mag[i]     = q_word.d[i][DIFF_W-1] ? (DIFF_W'(0) - q_word.d[i]) : q_word.d[i];
      num_nxt[i] = {1'b0, mag[i][MAG_W-1:0], FRAC_W'(0)} + NUM_W'(q_word.span >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (back_en) begin
      v_r[0] <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      w_r[0]   <= q_word;
      rem_r[0] <= num_nxt;
      quo_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_div
    localparam int B = STEPS - 1 - k;
    logic [NUM_W-1:0]           trial;
    logic [AXES-1:0][NUM_W-1:0] rem_nxt;
    logic [AXES-1:0][QUO_W-1:0] quo_nxt;

    assign trial = NUM_W'(w_r[k].span) << B;

    always_comb begin
      for (int i = 0; i < AXES; i++) begin
        if (rem_r[k][i] >= trial) begin
          rem_nxt[i] = rem_r[k][i] - trial;
          quo_nxt[i] = quo_r[k][i] | (QUO_W'(1) << B);
        end else begin
          rem_nxt[i] = rem_r[k][i];
          quo_nxt[i] = quo_r[k][i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (back_en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (back_en) begin
        w_r[k+1]   <= w_r[k];
        rem_r[k+1] <= rem_nxt;
        quo_r[k+1] <= quo_nxt;
      end
    end
  end

  // signed normal, zero for coincident points or no contact
  link_word_t                 wl;
  logic [AXES-1:0][NORM_W-1:0] norm_nxt;
  logic                       neg;

  always_comb begin
    wl = w_r[STEPS];
    for (int i = 0; i < AXES; i++) begin
      neg = wl.d[i][DIFF_W-1] ^ wl.flip;
      if (!wl.contact || wl.span == '0) begin
        norm_nxt[i] = '0;
      end else if (neg) begin
        norm_nxt[i] = NORM_W'(0) - {1'b0, quo_r[STEPS][i]};
      end else begin
        norm_nxt[i] = {1'b0, quo_r[STEPS][i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (back_en) begin
      out_v_r <= v_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      out_contact_valid     <= wl.contact;
      out_normal_x          <= norm_nxt[0];
      out_normal_y          <= norm_nxt[1];
      out_normal_z          <= norm_nxt[2];
      out_penetration_depth <= wl.contact ? wl.pen : '0;
      out_restitution_out   <= wl.contact ? wl.rest : '0;
    end
  end

endmodule

// ===== rtl/link_length_contact_generator_top.sv =====
// Throughput: one word per cycle while the output is popped; the 33-stage
// square root and the 17-stage divider pipelines each retire one word every
// cycle unless back-pressure from out_pop or a full queue stalls them.
// Reset: rst_n synchronous, active low; clears pipeline valids and queue.
// ----------------------------------------------------------------------------
// link_length_contact_generator_top
// Cable and rod contact generation between two points in fixed point.
// ----------------------------------------------------------------------------
module link_length_contact_generator_top import llcg_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic                in_link_kind,
  input  logic [COORD_W-1:0]  in_point_a_x,
  input  logic [COORD_W-1:0]  in_point_a_y,
  input  logic [COORD_W-1:0]  in_point_a_z,
  input  logic [COORD_W-1:0]  in_point_b_x,
  input  logic [COORD_W-1:0]  in_point_b_y,
  input  logic [COORD_W-1:0]  in_point_b_z,
  input  logic [LEN_W-1:0]    in_target_length,
  input  logic [REST_W-1:0]   in_restitution_in,
  output logic                out_empty,
  input  logic                out_pop,
  output logic                out_contact_valid,
  output logic [NORM_W-1:0]   out_normal_x,
  output logic [NORM_W-1:0]   out_normal_y,
  output logic [NORM_W-1:0]   out_normal_z,
  output logic [PEN_W-1:0]    out_penetration_depth,
  output logic [REST_W-1:0]   out_restitution_out
);

  link_word_t push_word;
  link_word_t head_word;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;

  llcg_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_link_kind      (in_link_kind),
    .in_point_a_x      (in_point_a_x),
    .in_point_a_y      (in_point_a_y),
    .in_point_a_z      (in_point_a_z),
    .in_point_b_x      (in_point_b_x),
    .in_point_b_y      (in_point_b_y),
    .in_point_b_z      (in_point_b_z),
    .in_target_length  (in_target_length),
    .in_restitution_in (in_restitution_in),
    .q_word            (push_word),
    .q_push            (q_push),
    .q_full            (q_full)
  );

  llcg_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (push_word),
    .full      (q_full),
    .pop       (q_pop),
    .head_word (head_word),
    .empty     (q_empty)
  );

  llcg_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_word                (head_word),
    .q_empty               (q_empty),
    .q_pop                 (q_pop),
    .out_empty             (out_empty),
    .out_pop               (out_pop),
    .out_contact_valid     (out_contact_valid),
    .out_normal_x          (out_normal_x),
    .out_normal_y          (out_normal_y),
    .out_normal_z          (out_normal_z),
    .out_penetration_depth (out_penetration_depth),
    .out_restitution_out   (out_restitution_out)
  );

endmodule
